@@ rtl/rttq_pkg.sv @@
// rttq_pkg: shared types and constants for the rooted tree table query block
// holds node id widths, the "none" code, result kinds, opcodes and the
// link request and table entry structs; no dependencies
package rttq_pkg;

    // id and table entry widths, fixed by the item fields
    localparam int ID_W   = 6;
    localparam int NODE_W = 7;

    // "none" as stored in a table entry (-1 in seven bits)
    localparam logic [NODE_W-1:0] NONE = 7'h7F;

    // walk limits: depth saturates at this count, child run stops at it
    localparam logic [ID_W-1:0] MAX_WALK = 6'd63;
    localparam logic [ID_W-1:0] LAST_CNT = 6'd62;

    // opcodes
    localparam logic OP_LINK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // node kinds
    localparam logic [1:0] KIND_ROOT  = 2'd0;
    localparam logic [1:0] KIND_LEAF  = 2'd1;
    localparam logic [1:0] KIND_INNER = 2'd2;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [NODE_W-1:0] t_node;

    // link write request from the sequencer to the tables
    typedef struct packed {
        logic en;
        logic first;
        t_id  par;
        t_id  child;
    } t_link_req;

    // one row read from all three tables, none where never written
    typedef struct packed {
        t_node par;
        t_node fc;
        t_node ns;
    } t_entry;

endpackage

@@ rtl/rttq_if.sv @@
// rttq_if: valid/ready channels for input items and result items
// depends on nothing; widths follow the item field widths

// input item channel
interface rttq_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic       first_child;

    modport source (output valid, output opcode, output node_a, output node_b,
                    output first_child, input ready);
    modport sink   (input valid, input opcode, input node_a, input node_b,
                    input first_child, output ready);
endinterface

// result item channel
interface rttq_out_if;
    logic              valid;
    logic              ready;
    logic signed [6:0] parent_of_node;
    logic        [5:0] node_depth;
    logic        [1:0] node_kind;
    logic signed [6:0] child_id;
    logic              last_of_run;

    modport source (output valid, output parent_of_node, output node_depth,
                    output node_kind, output child_id, output last_of_run,
                    input ready);
    modport sink   (input valid, input parent_of_node, input node_depth,
                    input node_kind, input child_id, input last_of_run,
                    output ready);
endinterface

@@ rtl/rttq_tables.sv @@
// rttq_tables: parent, first-child and next-sibling memories with valid bits
// one link write per cycle, one shared registered read port for all three
// depends on rttq_pkg
module rttq_tables #(
    parameter int NODES = 64,
    localparam int AW   = $clog2(NODES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rttq_pkg::t_link_req i_link,
    input  logic [AW-1:0]      i_rd_addr,
    output rttq_pkg::t_entry   o_entry
);

    // table storage, ids only; the valid bits stand for "none"
    rttq_pkg::t_id r_par_mem [NODES];
    rttq_pkg::t_id r_fc_mem  [NODES];
    rttq_pkg::t_id r_ns_mem  [NODES];

    logic [NODES-1:0] r_par_vld;
    logic [NODES-1:0] r_fc_vld;
    logic [NODES-1:0] r_ns_vld;
    logic [AW-1:0]    r_prev;

    rttq_pkg::t_id r_rd_par;
    rttq_pkg::t_id r_rd_fc;
    rttq_pkg::t_id r_rd_ns;
    logic          r_rd_par_v;
    logic          r_rd_fc_v;
    logic          r_rd_ns_v;

    logic [AW-1:0] w_a;
    logic [AW-1:0] w_b;

    assign w_a = i_link.par[AW-1:0];
    assign w_b = i_link.child[AW-1:0];

    // memory writes for a link
    always_ff @(posedge i_clk) begin
        if (i_link.en) begin
            r_par_mem[w_b] <= i_link.par;
            if (i_link.first) begin
                r_fc_mem[w_a] <= i_link.child;
            end else begin
                r_ns_mem[r_prev] <= i_link.child;
            end
        end
    end

    // valid bits and previously linked child
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_vld <= '0;
            r_fc_vld  <= '0;
            r_ns_vld  <= '0;
            r_prev    <= '0;
        end else if (i_link.en) begin
            r_par_vld[w_b] <= 1'b1;
            if (i_link.first) begin
                r_fc_vld[w_a] <= 1'b1;
            end else begin
                r_ns_vld[r_prev] <= 1'b1;
            end
            r_prev <= w_b;
        end
    end

    // shared registered read port
    always_ff @(posedge i_clk) begin
        r_rd_par   <= r_par_mem[i_rd_addr];
        r_rd_fc    <= r_fc_mem[i_rd_addr];
        r_rd_ns    <= r_ns_mem[i_rd_addr];
        r_rd_par_v <= r_par_vld[i_rd_addr];
        r_rd_fc_v  <= r_fc_vld[i_rd_addr];
        r_rd_ns_v  <= r_ns_vld[i_rd_addr];
    end

    // entries never written read as none
    assign o_entry.par = r_rd_par_v ? {1'b0, r_rd_par} : rttq_pkg::NONE;
    assign o_entry.fc  = r_rd_fc_v  ? {1'b0, r_rd_fc}  : rttq_pkg::NONE;
    assign o_entry.ns  = r_rd_ns_v  ? {1'b0, r_rd_ns}  : rttq_pkg::NONE;

endmodule

@@ rtl/rttq_seq.sv @@
// rttq_seq: sequencer that drives the shared table read port
// walks the parent chain, then the sibling list, and holds the result register
// depends on rttq_pkg and rttq_if
module rttq_seq #(
    parameter int NODES = 64,
    localparam int AW   = $clog2(NODES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rttq_in_if.sink             i_in,
    rttq_out_if.source          o_out,
    output rttq_pkg::t_link_req o_link,
    output logic [AW-1:0]       o_rd_addr,
    input  rttq_pkg::t_entry    i_entry
);

    localparam logic [rttq_pkg::NODE_W-1:0] NODE_LIM = rttq_pkg::NODE_W'(NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE_D,
        S_WALK,
        S_CHRD,
        S_CHD,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    rttq_pkg::t_node     r_par,   n_par;
    rttq_pkg::t_id       r_dep,   n_dep;
    logic [1:0]          r_kind,  n_kind;
    rttq_pkg::t_node     r_child, n_child;
    rttq_pkg::t_node     r_nxt,   n_nxt;
    rttq_pkg::t_id       r_cnt,   n_cnt;

    logic                r_ov,     n_ov;
    rttq_pkg::t_node     r_o_par,  n_o_par;
    rttq_pkg::t_id       r_o_dep,  n_o_dep;
    logic [1:0]          r_o_kind, n_o_kind;
    rttq_pkg::t_node     r_o_child, n_o_child;
    logic                r_o_last, n_o_last;

    logic                w_accept;
    logic                w_a_ok;
    logic                w_b_ok;
    logic                w_free;
    logic                w_last;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_a_ok   = {1'b0, i_in.node_a} < NODE_LIM;
    assign w_b_ok   = {1'b0, i_in.node_b} < NODE_LIM;
    assign w_free   = !r_ov || o_out.ready;
    assign w_last   = (r_nxt == rttq_pkg::NONE) || (r_cnt == rttq_pkg::LAST_CNT);

    // handshake and result port
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.parent_of_node = $signed(r_o_par);
    assign o_out.node_depth     = r_o_dep;
    assign o_out.node_kind      = r_o_kind;
    assign o_out.child_id       = $signed(r_o_child);
    assign o_out.last_of_run    = r_o_last;

    // link write goes straight to the tables
    always_comb begin
        o_link.en    = w_accept && (i_in.opcode == rttq_pkg::OP_LINK) && w_a_ok && w_b_ok;
        o_link.first = i_in.first_child;
        o_link.par   = i_in.node_a;
        o_link.child = i_in.node_b;
    end

    // read address for the next table row
    always_comb begin
        case (r_state)
            S_IDLE:   o_rd_addr = i_in.node_a[AW-1:0];
            S_NODE_D: o_rd_addr = i_entry.par[AW-1:0];
            S_WALK:   o_rd_addr = i_entry.par[AW-1:0];
            S_CHRD:   o_rd_addr = r_child[AW-1:0];
            default:  o_rd_addr = '0;
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_par     = r_par;
        n_dep     = r_dep;
        n_kind    = r_kind;
        n_child   = r_child;
        n_nxt     = r_nxt;
        n_cnt     = r_cnt;
        n_ov      = r_ov;
        n_o_par   = r_o_par;
        n_o_dep   = r_o_dep;
        n_o_kind  = r_o_kind;
        n_o_child = r_o_child;
        n_o_last  = r_o_last;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.opcode == rttq_pkg::OP_QUERY)) begin
                    if (w_a_ok) begin
                        n_state = S_NODE_D;
                    end else begin
                        // unknown node: one root-like result with no children
                        n_par   = rttq_pkg::NONE;
                        n_dep   = '0;
                        n_kind  = rttq_pkg::KIND_ROOT;
                        n_child = rttq_pkg::NONE;
                        n_nxt   = rttq_pkg::NONE;
                        n_cnt   = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_NODE_D: begin
                n_par   = i_entry.par;
                n_child = i_entry.fc;
                n_cnt   = '0;
                if (i_entry.par == rttq_pkg::NONE) begin
                    n_kind = rttq_pkg::KIND_ROOT;
                end else if (i_entry.fc == rttq_pkg::NONE) begin
                    n_kind = rttq_pkg::KIND_LEAF;
                end else begin
                    n_kind = rttq_pkg::KIND_INNER;
                end
                if (i_entry.par == rttq_pkg::NONE) begin
                    n_dep   = '0;
                    n_state = S_CHRD;
                end else begin
                    n_dep   = rttq_pkg::ID_W'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // one parent step per cycle, saturating
                if ((i_entry.par == rttq_pkg::NONE) || (r_dep == rttq_pkg::MAX_WALK)) begin
                    n_state = S_CHRD;
                end else begin
                    n_dep = r_dep + rttq_pkg::ID_W'(1);
                end
            end
            S_CHRD: begin
                if (r_child == rttq_pkg::NONE) begin
                    n_nxt   = rttq_pkg::NONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CHD;
                end
            end
            S_CHD: begin
                n_nxt   = i_entry.ns;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ov      = 1'b1;
                    n_o_par   = r_par;
                    n_o_dep   = r_dep;
                    n_o_kind  = r_kind;
                    n_o_child = r_child;
                    n_o_last  = w_last;
                    n_child   = r_nxt;
                    n_cnt     = r_cnt + rttq_pkg::ID_W'(1);
                    n_state   = w_last ? S_IDLE : S_CHRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ov      <= n_ov;
            r_par     <= n_par;
            r_dep     <= n_dep;
            r_kind    <= n_kind;
            r_child   <= n_child;
            r_nxt     <= n_nxt;
            r_cnt     <= n_cnt;
            r_o_par   <= n_o_par;
            r_o_dep   <= n_o_dep;
            r_o_kind  <= n_o_kind;
            r_o_child <= n_o_child;
            r_o_last  <= n_o_last;
        end
    end

endmodule

@@ rtl/rooted_tree_table_query_core.sv @@
// rooted_tree_table_query_core: left-child/right-sibling tree with link and query
// a link item is written straight to the tables; a query walks the parent chain,
// then the sibling list for one result item per child, held up by output stalls,
// all on the single shared table read port; no new item is taken until the last
// result is registered; synchronous active-low reset clears the table valid bits,
// so there is no clearing pass; depends on rttq_pkg, rttq_if, rttq_tables, rttq_seq
module rooted_tree_table_query_core #(
    parameter int NODES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rttq_in_if.sink    i_in,
    rttq_out_if.source o_out
);

    localparam int AW = $clog2(NODES);

    rttq_pkg::t_link_req w_link;
    rttq_pkg::t_entry    w_entry;
    logic [AW-1:0]       w_rd_addr;

    // sequencer
    rttq_seq #(
        .NODES (NODES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_link    (w_link),
        .o_rd_addr (w_rd_addr),
        .i_entry   (w_entry)
    );

    // tree tables
    rttq_tables #(
        .NODES (NODES)
    ) u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_link    (w_link),
        .i_rd_addr (w_rd_addr),
        .o_entry   (w_entry)
    );

endmodule

@@ rtl/rttq_checker.sv @@
// rttq_checker: port-level checks on the result channel of the core
// depends on rttq_pkg; bound to rooted_tree_table_query_core below
module rttq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_parent,
    input logic [5:0] i_depth,
    input logic [1:0] i_kind,
    input logic [6:0] i_child,
    input logic       i_last
);

    // stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable({i_parent, i_depth, i_kind, i_child, i_last})))
        else $error("result changed while stalled");

    // a root has no parent and depth zero, and only a root lacks a parent
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_kind == rttq_pkg::KIND_ROOT) == (i_parent == rttq_pkg::NONE)) &&
             ((i_kind != rttq_pkg::KIND_ROOT) || (i_depth == 6'd0))))
        else $error("root kind disagrees with parent or depth");

    // a leaf reports no child
    a_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == rttq_pkg::KIND_LEAF)) |-> (i_child == rttq_pkg::NONE))
        else $error("leaf reported a child");

    // an empty child slot ends the run and never comes from an internal node
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_child == rttq_pkg::NONE)) |->
            (i_last && (i_kind != rttq_pkg::KIND_INNER)))
        else $error("empty child slot not final or from internal node");

endmodule

bind rooted_tree_table_query_core rttq_checker u_rttq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_parent    (o_out.parent_of_node),
    .i_depth     (o_out.node_depth),
    .i_kind      (o_out.node_kind),
    .i_child     (o_out.child_id),
    .i_last      (o_out.last_of_run)
);

@@ tb/sv/rooted_tree_table_query_core_tb.sv @@
// rooted_tree_table_query_core_tb: self-checking bench for the tree table query core
// predicts every query answer from its own copy of the three tables and compares
// each result item field by field; depends on rttq_pkg, rttq_if and the core

// one expected or observed result item
typedef struct packed {
    logic signed [6:0] parent_of_node;
    logic        [5:0] node_depth;
    logic        [1:0] node_kind;
    logic signed [6:0] child_id;
    logic              last_of_run;
} t_tree_answer;

// shadow tree tables plus the queue of answers still owed by the core
class tree_answer_board;
    int unsigned  nodes;
    logic [6:0]   parent_tab[64];
    logic [6:0]   first_child_tab[64];
    logic [6:0]   next_sibling_tab[64];
    logic [5:0]   last_linked;
    t_tree_answer pending_answers[$];
    int unsigned  errors;
    int unsigned  items_seen;
    int unsigned  queries_seen;
    int unsigned  answers_checked;
    int unsigned  saturated_depths;
    int unsigned  longest_run;

    function new(int unsigned node_count);
        nodes = node_count;
        foreach (parent_tab[i]) begin
            parent_tab[i]       = rttq_pkg::NONE;
            first_child_tab[i]  = rttq_pkg::NONE;
            next_sibling_tab[i] = rttq_pkg::NONE;
        end
        last_linked      = '0;
        errors           = 0;
        items_seen       = 0;
        queries_seen     = 0;
        answers_checked  = 0;
        saturated_depths = 0;
        longest_run      = 0;
    endfunction

    // update the tables for a link, or queue the answers a query owes
    function void predict_answers(logic op, logic [5:0] a, logic [5:0] b, logic fc);
        t_tree_answer ans;
        logic [6:0]   cur;
        logic [6:0]   up;
        logic [6:0]   child;
        int unsigned  steps;
        int unsigned  count;
        items_seen++;
        if (op == rttq_pkg::OP_LINK) begin
            if (a < nodes && b < nodes) begin
                parent_tab[b] = {1'b0, a};
                if (fc)
                    first_child_tab[a] = {1'b0, b};
                else
                    next_sibling_tab[last_linked] = {1'b0, b};
                last_linked = b;
            end
            return;
        end
        queries_seen++;
        // id beyond the table: a single empty root answer
        if (a >= nodes) begin
            ans.parent_of_node = rttq_pkg::NONE;
            ans.node_depth     = '0;
            ans.node_kind      = rttq_pkg::KIND_ROOT;
            ans.child_id       = rttq_pkg::NONE;
            ans.last_of_run    = 1'b1;
            pending_answers.push_back(ans);
            return;
        end
        // parent chain walk, saturating on loops
        steps = 0;
        cur   = {1'b0, a};
        while (steps < 63) begin
            up = parent_tab[cur[5:0]];
            if (up == rttq_pkg::NONE)
                break;
            cur = up;
            steps++;
        end
        if (steps == 63)
            saturated_depths++;
        ans.parent_of_node = parent_tab[a];
        ans.node_depth     = steps[5:0];
        if (parent_tab[a] == rttq_pkg::NONE)
            ans.node_kind = rttq_pkg::KIND_ROOT;
        else if (first_child_tab[a] == rttq_pkg::NONE)
            ans.node_kind = rttq_pkg::KIND_LEAF;
        else
            ans.node_kind = rttq_pkg::KIND_INNER;
        // sibling list walk, one answer per child, capped at 63
        child = first_child_tab[a];
        count = 0;
        forever begin
            ans.child_id = child;
            count++;
            if (child != rttq_pkg::NONE)
                child = next_sibling_tab[child[5:0]];
            ans.last_of_run = (child == rttq_pkg::NONE) || (count >= 63);
            pending_answers.push_back(ans);
            if (ans.last_of_run)
                break;
        end
        if (count > longest_run)
            longest_run = count;
    endfunction

    // compare one result item with the oldest pending answer
    function void check_answer(t_tree_answer got);
        t_tree_answer exp;
        answers_checked++;
        if (pending_answers.size() == 0) begin
            $error("unexpected result item: child_id %0d last_of_run %0d",
                   got.child_id, got.last_of_run);
            errors++;
            return;
        end
        exp = pending_answers.pop_front();
        if (got.parent_of_node !== exp.parent_of_node) begin
            $error("parent_of_node: expected %0d, got %0d",
                   exp.parent_of_node, got.parent_of_node);
            errors++;
        end
        if (got.node_depth !== exp.node_depth) begin
            $error("node_depth: expected %0d, got %0d", exp.node_depth, got.node_depth);
            errors++;
        end
        if (got.node_kind !== exp.node_kind) begin
            $error("node_kind: expected %0d, got %0d", exp.node_kind, got.node_kind);
            errors++;
        end
        if (got.child_id !== exp.child_id) begin
            $error("child_id: expected %0d, got %0d", exp.child_id, got.child_id);
            errors++;
        end
        if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", exp.last_of_run, got.last_of_run);
            errors++;
        end
    endfunction
endclass

module rooted_tree_table_query_core_tb;

    localparam int TREE_NODES   = 64;
    localparam int DRAIN_LIMIT  = 40000;
    localparam int SETTLE_WAIT  = 300;
    localparam int HOLD_CYCLES  = 500;

    logic i_clk;
    logic i_rst_n;

    rttq_in_if  in_ch ();
    rttq_out_if out_ch ();

    rooted_tree_table_query_core #(
        .NODES (TREE_NODES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tree_answer_board board;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      hold_left;
    int unsigned      max_hold_seen;

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // run limit
    initial begin
        #4000000;
        $display("rooted_tree_table_query_core verification failed");
        $finish;
    end

    // result side: check at each edge, then pick the next ready level
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                board.check_answer('{out_ch.parent_of_node, out_ch.node_depth,
                                     out_ch.node_kind, out_ch.child_id,
                                     out_ch.last_of_run});
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // offer one item and wait until the core takes it
    task automatic send_item(input logic op, input logic [5:0] a, input logic [5:0] b,
                             input logic fc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.node_a      <= a;
        in_ch.node_b      <= b;
        in_ch.first_child <= fc;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        board.predict_answers(op, a, b, fc);
    endtask

    task automatic link(input logic [5:0] par, input logic [5:0] child, input logic fc);
        send_item(rttq_pkg::OP_LINK, par, child, fc);
    endtask

    task automatic query(input logic [5:0] node);
        send_item(rttq_pkg::OP_QUERY, node, 6'($urandom), 1'($urandom));
    endtask

    // random traffic: mostly sibling families followed by queries, some noise
    task automatic run_random(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        int unsigned kids;
        logic [5:0]  par;
        logic [5:0]  child;
        target = board.items_seen + count;
        while (board.items_seen < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                par  = 6'($urandom);
                kids = $urandom_range(1, 4);
                for (int k = 0; k < kids; k++) begin
                    child = 6'($urandom);
                    link(par, child, k == 0);
                end
                query(par);
                if ($urandom_range(0, 1))
                    query(child);
            end else if (pick < 85) begin
                query(6'($urandom));
            end else begin
                link(6'($urandom), 6'($urandom), 1'($urandom));
            end
        end
    endtask

    // main sequence
    initial begin
        int unsigned waited;
        board          = new(TREE_NODES);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        max_hold_seen  = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= rttq_pkg::OP_LINK;
        in_ch.node_a      <= '0;
        in_ch.node_b      <= '0;
        in_ch.first_child <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables: lone root with no children
        query(6'd0);
        // sibling link before any other link lands on node zero's sibling entry
        link(6'd0, 6'd5, 1'b0);
        query(6'd5);
        query(6'd0);
        // small family under node zero, grandchild chain down to node 62
        link(6'd0, 6'd1, 1'b1);
        link(6'd0, 6'd2, 1'b0);
        link(6'd0, 6'd63, 1'b0);
        link(6'd1, 6'd4, 1'b1);
        link(6'd4, 6'd62, 1'b1);
        query(6'd0);
        query(6'd1);
        query(6'd62);
        query(6'd63);
        // relinking moves node 63 under node 62
        link(6'd62, 6'd63, 1'b1);
        query(6'd63);
        // parent loop saturates the depth
        link(6'd10, 6'd11, 1'b1);
        link(6'd11, 6'd10, 1'b1);
        query(6'd10);
        // sibling self loop caps the child run
        link(6'd20, 6'd21, 1'b1);
        link(6'd20, 6'd21, 1'b0);
        query(6'd20);
        send_item(rttq_pkg::OP_QUERY, 6'd63, 6'd63, 1'b1);

        // random phases with different idling on each side
        run_random(55);
        send_idle_pct = 73;
        run_random(55);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        run_random(55);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random(55);

        // long receiver hold while queries keep coming, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        max_hold_seen  = HOLD_CYCLES;
        for (int q = 0; q < 30; q++)
            query(6'($urandom));
        run_random(30);
        in_ch.valid <= 1'b0;

        // wait for the last answers, then let the core settle
        waited = 0;
        while (board.pending_answers.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (board.pending_answers.size() > 0) begin
            $error("%0d answers never arrived", board.pending_answers.size());
            board.errors++;
        end

        $display("sent %0d items (%0d queries), checked %0d result items",
                 board.items_seen, board.queries_seen, board.answers_checked);
        $display("longest child run %0d, saturated depths %0d, receiver hold %0d cycles",
                 board.longest_run, board.saturated_depths, max_hold_seen);
        if (board.errors == 0)
            $display("rooted_tree_table_query_core verification clean");
        else
            $display("rooted_tree_table_query_core verification failed");
        $finish;
    end

endmodule
